FILE: src/sce_pkg.sv
`timescale 1ns / 1ps
package sce_pkg;

  localparam int LINE_CAPACITY_DEF = 32;
  localparam int LEN_W             = 5;
  localparam int LEN_MAX           = 31;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_NL    = 8'h0a;

  typedef enum logic [1:0] {
    K_ECHO = 2'd0,
    K_LINE = 2'd1,
    K_DONE = 2'd2,
    K_ESC  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ESC_NONE   = 2'd0,
    ESC_FIRST  = 2'd1,
    ESC_SECOND = 2'd2
  } esc_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_ESC     = 4'd1,
    ST_ECHO    = 4'd2,
    ST_BS1     = 4'd3,
    ST_BS2     = 4'd4,
    ST_BS3     = 4'd5,
    ST_CR_RD   = 4'd6,
    ST_CR_EMIT = 4'd7,
    ST_DONE    = 4'd8,
    ST_NL      = 4'd9,
    ST_RET     = 4'd10
  } step_t;

  typedef enum logic [2:0] {
    DS_BYTE, DS_MEM, DS_ZERO, DS_NL, DS_CR, DS_BS, DS_SP, DS_ESC
  } dsel_t;

  typedef enum logic [1:0] {
    BR_DISPATCH, BR_NEXT, BR_JUMP, BR_IF_END
  } branch_t;

  typedef enum logic [1:0] {
    OP_NONE, OP_IDX_INC, OP_FILL_CLR
  } uop_t;

  typedef struct packed {
    logic    emit;
    kind_t   kind;
    dsel_t   dsel;
    logic    last;
    branch_t br;
    step_t   target;
    uop_t    op;
  } uword_t;

  // Control store: one word per step.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{emit: 1'b0, kind: K_ECHO, dsel: DS_ZERO, last: 1'b0,
          br: BR_DISPATCH, target: ST_IDLE, op: OP_NONE};
    unique case (s)
      ST_IDLE:    w.br = BR_DISPATCH;
      ST_ESC:     w = '{1'b1, K_ESC,  DS_ESC,  1'b1, BR_JUMP,   ST_IDLE,  OP_NONE};
      ST_ECHO:    w = '{1'b1, K_ECHO, DS_BYTE, 1'b1, BR_JUMP,   ST_IDLE,  OP_NONE};
      ST_BS1:     w = '{1'b1, K_ECHO, DS_BS,   1'b0, BR_NEXT,   ST_IDLE,  OP_NONE};
      ST_BS2:     w = '{1'b1, K_ECHO, DS_SP,   1'b0, BR_NEXT,   ST_IDLE,  OP_NONE};
      ST_BS3:     w = '{1'b1, K_ECHO, DS_BS,   1'b1, BR_JUMP,   ST_IDLE,  OP_NONE};
      ST_CR_RD:   w = '{1'b0, K_ECHO, DS_ZERO, 1'b0, BR_IF_END, ST_DONE,  OP_NONE};
      ST_CR_EMIT: w = '{1'b1, K_LINE, DS_MEM,  1'b0, BR_JUMP,   ST_CR_RD, OP_IDX_INC};
      ST_DONE:    w = '{1'b1, K_DONE, DS_ZERO, 1'b0, BR_NEXT,   ST_IDLE,  OP_NONE};
      ST_NL:      w = '{1'b1, K_ECHO, DS_NL,   1'b0, BR_NEXT,   ST_IDLE,  OP_NONE};
      ST_RET:     w = '{1'b1, K_ECHO, DS_CR,   1'b1, BR_JUMP,   ST_IDLE,  OP_FILL_CLR};
      default:    w.br = BR_JUMP;
    endcase
    return w;
  endfunction

endpackage

FILE: src/sce_in_if.sv
`timescale 1ns / 1ps
interface sce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: src/sce_out_if.sv
`timescale 1ns / 1ps
interface sce_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data;
  logic [7:0] second_data;
  logic [4:0] line_length;
  logic       last;

  modport source (output valid, output kind, output data, output second_data,
                  output line_length, output last, input ready);
  modport sink   (input valid, input kind, input data, input second_data,
                  input line_length, input last, output ready);
endinterface

FILE: src/serial_console_line_editor_unit.sv
`timescale 1ns / 1ps
// A printable byte's echo word is loaded into the output register from the echo step that follows acceptance.
// A microcoded sequencer issues one control word per cycle while the output is not
// stalled. A carriage return reads and emits each stored byte, then emits line done,
// newline and CR; backspace echoes BS, space, BS. One input word per command sequence.
// Reset (synchronous, rst high) empties the line, leaves escape and idles.
module serial_console_line_editor_unit #(
  parameter int LINE_CAPACITY = sce_pkg::LINE_CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst,
  sce_in_if.sink           rx,
  sce_out_if.source        tx
);
  import sce_pkg::*;

  localparam int FW = $clog2(LINE_CAPACITY);
  localparam logic [FW-1:0] FILL_TOP = FW'(LINE_CAPACITY - 1);

  // Sequencer state
  step_t          step, step_next, dispatch;
  uword_t         uw;
  logic           hold;
  logic           out_load;
  logic           acc;

  // Datapath registers
  logic [FW-1:0]  fill;
  logic [FW-1:0]  idx;
  esc_t           esc_phase;
  logic [7:0]     esc_first;
  logic [7:0]     cur_byte;
  logic [7:0]     rdata;
  logic [7:0]     mem [LINE_CAPACITY];
  logic           mem_we;

  // Output register
  logic           out_valid;
  kind_t          out_kind;
  logic [7:0]     out_data;
  logic [7:0]     out_second;
  logic [LEN_W-1:0] out_len;
  logic           out_last;
  logic [7:0]     sel_data;
  logic [LEN_W-1:0] sat_len;

  assign acc    = rx.valid && rx.ready;
  assign mem_we = acc && (esc_phase == ESC_NONE) && (rx.rx_byte >= CH_SPACE);

  // Decode the incoming word into the entry step of its command sequence.
  always_comb begin
    dispatch = ST_IDLE;
    unique case (esc_phase)
      ESC_NONE: begin
        if (rx.rx_byte == CH_CR) begin
          dispatch = ST_CR_RD;
        end else if (rx.rx_byte == CH_BS) begin
          dispatch = (fill != '0) ? ST_BS1 : ST_IDLE;
        end else if (rx.rx_byte >= CH_SPACE) begin
          dispatch = ST_ECHO;
        end else begin
          dispatch = ST_IDLE;
        end
      end
      ESC_FIRST: dispatch = ST_IDLE;
      default:   dispatch = ST_ESC;
    endcase
  end

  // Sequencer: fetch the control word, stall emits on a full output register.
  always_comb begin
    uw        = ucode(step);
    step_next = step;
    rx.ready  = 1'b0;
    hold      = uw.emit && out_valid && !tx.ready;
    out_load  = uw.emit && !hold;
    unique case (uw.br)
      BR_DISPATCH: begin
        rx.ready = 1'b1;
        if (rx.valid) step_next = dispatch;
      end
      BR_NEXT: begin
        if (!hold) step_next = step_t'(4'(step) + 4'd1);
      end
      BR_JUMP: begin
        if (!hold) step_next = uw.target;
      end
      BR_IF_END: begin
        step_next = (idx == fill) ? uw.target : step_t'(4'(step) + 4'd1);
      end
      default: step_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Line state: updated on acceptance and by the micro-ops.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      esc_phase <= ESC_NONE;
      esc_first <= '0;
    end else if (acc) begin
      unique case (esc_phase)
        ESC_NONE: begin
          if (rx.rx_byte == CH_BS) begin
            if (fill != '0) fill <= fill - 1'b1;
          end else if (rx.rx_byte >= CH_SPACE) begin
            if (fill != FILL_TOP) fill <= fill + 1'b1;
          end else if (rx.rx_byte == CH_ESC) begin
            esc_phase <= ESC_FIRST;
          end
        end
        ESC_FIRST: begin
          esc_first <= rx.rx_byte;
          esc_phase <= ESC_SECOND;
        end
        default: esc_phase <= ESC_NONE;
      endcase
    end else if (out_load && uw.op == OP_FILL_CLR) begin
      fill <= '0;
    end
  end

  // Read pointer and latched input word.
  always_ff @(posedge clk) begin
    if (acc) begin
      cur_byte <= rx.rx_byte;
      idx      <= '0;
    end else if (out_load && uw.op == OP_IDX_INC) begin
      idx <= idx + 1'b1;
    end
  end

  // Line store: write at the fill position, registered read at the pointer.
  always_ff @(posedge clk) begin
    if (mem_we) mem[fill] <= rx.rx_byte;
    rdata <= mem[idx];
  end

  always_comb begin
    case (uw.dsel)
      DS_BYTE: sel_data = cur_byte;
      DS_MEM:  sel_data = rdata;
      DS_NL:   sel_data = CH_NL;
      DS_CR:   sel_data = CH_CR;
      DS_BS:   sel_data = CH_BS;
      DS_SP:   sel_data = CH_SPACE;
      DS_ESC:  sel_data = esc_first;
      default: sel_data = '0;
    endcase
    if (32'(fill) > 32'(LEN_MAX)) begin
      sat_len = LEN_W'(LEN_MAX);
    end else begin
      sat_len = LEN_W'(fill);
    end
  end

  // Output register: refill in the cycle the held word leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind   <= uw.kind;
      out_data   <= sel_data;
      out_second <= (uw.kind == K_ESC) ? cur_byte : 8'd0;
      out_len    <= (uw.kind == K_DONE) ? sat_len : '0;
      out_last   <= uw.last;
    end
  end

  assign tx.valid       = out_valid;
  assign tx.kind        = out_kind;
  assign tx.data        = out_data;
  assign tx.second_data = out_second;
  assign tx.line_length = out_len;
  assign tx.last        = out_last;

`ifndef ASSERT_OFF
  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && uw.last) |=> (step == ST_IDLE))
    else $error("sequence did not return to idle after its final word");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (step == ST_CR_EMIT) |-> (idx < fill))
    else $error("line read beyond the stored bytes");

  a_len_only_done: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.kind != K_DONE) |-> (tx.line_length == '0))
    else $error("length reported on a word that is not line done");

  a_bs_shrinks: assert property (@(posedge clk) disable iff (rst)
    (acc && esc_phase == ESC_NONE && rx.rx_byte == CH_BS && fill != '0)
      |=> (fill == $past(fill) - 1'b1))
    else $error("backspace did not remove one byte");
`endif

endmodule

FILE: tb/tb_serial_console_line_editor_unit.sv
`timescale 1ns / 1ps

module tb_serial_console_line_editor_unit;
  import sce_pkg::*;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] second_data;
    logic [4:0] line_length;
    logic       last;
  } console_word_t;

  // Tracks the console line as the block should see it and holds the words due.
  class console_line_tracker;
    localparam int CAP = LINE_CAPACITY_DEF;

    logic [7:0]    line_buf [CAP];
    int unsigned   fill;
    esc_t          esc_state;
    logic [7:0]    esc_lead;
    console_word_t due_words [$];
    int unsigned   words_matched;
    int unsigned   lines_closed;
    int unsigned   escapes_seen;
    int unsigned   overwrites;

    function void clear_line_state();
      foreach (line_buf[i]) line_buf[i] = '0;
      fill      = 0;
      esc_state = ESC_NONE;
      esc_lead  = '0;
    endfunction

    function void add_due(kind_t k, logic [7:0] d, logic [7:0] d2, int unsigned len);
      console_word_t w;
      w.kind        = k;
      w.data        = d;
      w.second_data = d2;
      w.line_length = (len > LEN_MAX) ? 5'(LEN_MAX) : 5'(len);
      w.last        = 1'b0;
      due_words.push_back(w);
    endfunction

    // Apply one received byte; returns 1 unless the byte is ignored outright.
    function bit take_rx_byte(logic [7:0] b);
      int unsigned before_n;
      bit          acted;
      before_n = due_words.size();
      acted    = 1'b1;
      if (esc_state == ESC_FIRST) begin
        esc_lead  = b;
        esc_state = ESC_SECOND;
      end else if (esc_state != ESC_NONE) begin
        add_due(K_ESC, esc_lead, b, 0);
        esc_state = ESC_NONE;
        escapes_seen++;
      end else if (b == CH_CR) begin
        for (int i = 0; i < fill; i++) add_due(K_LINE, line_buf[i], '0, 0);
        add_due(K_DONE, '0, '0, fill);
        add_due(K_ECHO, CH_NL, '0, 0);
        add_due(K_ECHO, CH_CR, '0, 0);
        fill = 0;
        lines_closed++;
      end else if (b == CH_BS) begin
        if (fill > 0) begin
          fill--;
          add_due(K_ECHO, CH_BS, '0, 0);
          add_due(K_ECHO, CH_SPACE, '0, 0);
          add_due(K_ECHO, CH_BS, '0, 0);
        end else begin
          acted = 1'b0;
        end
      end else if (b >= CH_SPACE) begin
        if (fill >= CAP - 1) overwrites++;
        if (fill >= CAP) fill = CAP - 1;
        line_buf[fill] = b;
        fill++;
        if (fill >= CAP) fill = CAP - 1;
        add_due(K_ECHO, b, '0, 0);
      end else if (b == CH_ESC) begin
        esc_state = ESC_FIRST;
      end else begin
        acted = 1'b0;
      end
      if (due_words.size() > before_n) due_words[due_words.size() - 1].last = 1'b1;
      return acted;
    endfunction

    // Returns an empty string on a match, else a one-line description.
    function string match_tx_word(console_word_t got);
      console_word_t want;
      if (due_words.size() == 0)
        return $sformatf("unexpected word kind %s data %02h", got.kind.name(), got.data);
      want = due_words.pop_front();
      if (got.kind !== want.kind || got.data !== want.data ||
          got.second_data !== want.second_data ||
          got.line_length !== want.line_length || got.last !== want.last)
        return $sformatf("got %s %02h/%02h len %0d last %0b, want %s %02h/%02h len %0d last %0b",
                         got.kind.name(), got.data, got.second_data, got.line_length,
                         got.last, want.kind.name(), want.data, want.second_data,
                         want.line_length, want.last);
      words_matched++;
      return "";
    endfunction

    function int unsigned pending();
      return due_words.size();
    endfunction
  endclass

  localparam int LINE_CAP    = LINE_CAPACITY_DEF;
  localparam int RANDOM_GOAL = 200;
  // Long enough for the editor to park on a full carriage-return sequence.
  localparam int HOLD_CYCLES = 300;
  // Cycles allowed after the final word for a byte that emits nothing.
  localparam int SETTLE      = 80;

  logic clk = 1'b0;
  logic rst;

  sce_in_if  rx_ch ();
  sce_out_if tx_ch ();

  serial_console_line_editor_unit #(
    .LINE_CAPACITY(LINE_CAP)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch.sink),
    .tx (tx_ch.source)
  );

  always #5 clk = ~clk;

  console_line_tracker tracker;
  int unsigned         mismatches = 0;
  int unsigned         bytes_taken = 0;
  bit                  hold_off_req = 1'b0;
  bit                  tx_calm = 1'b0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Offer one byte after a random gap and hold it until the editor takes it.
  // Valid stays high across back-to-back words so that it is never dropped
  // and raised in the same step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    if (tracker.take_rx_byte(b)) bytes_taken++;
  endtask

  // Drop valid straight after the last accepted word.
  task automatic park_sender();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold off until every expected word is back, then let the editor settle.
  task automatic wait_for_drain();
    park_sender();
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(CH_SPACE, 255));
  endfunction

  // A typed line with occasional edits and escapes, closed by carriage return.
  task automatic send_line(input int len);
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 15))
        0: send_byte(CH_BS);
        1: begin
          send_byte(CH_ESC);
          send_byte(8'($urandom_range(0, 255)));
          send_byte(8'($urandom_range(0, 255)));
        end
        default: ;
      endcase
      send_byte(printable());
    end
    send_byte(CH_CR);
  endtask

  // Collect words on the transmit side with random stalls and one long hold.
  initial begin : tx_side
    int            stall;
    bit            calm;
    console_word_t got;
    string         why;
    calm = 1'b0;
    tx_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        tx_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 19) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        tx_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      tx_ch.ready <= 1'b1;
      @(posedge clk);
      while (!tx_ch.valid) @(posedge clk);
      got.kind        = kind_t'(tx_ch.kind);
      got.data        = tx_ch.data;
      got.second_data = tx_ch.second_data;
      got.line_length = tx_ch.line_length;
      got.last        = tx_ch.last;
      why = tracker.match_tx_word(got);
      if (why != "") report_mismatch(why);
    end
  end

  initial begin : stimulus
    bit drained_mid;
    int guard;
    drained_mid   = 1'b0;
    tracker       = new;
    tracker.clear_line_state();
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    rst           <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: printable extremes, edit, both line ends, ignored controls.
    send_byte(CH_SPACE);
    send_byte(8'h7e);
    send_byte(8'h80);
    send_byte(8'hff);
    send_byte(CH_BS);
    send_byte(CH_CR);
    send_byte(CH_CR);            // empty line: length zero only
    send_byte(CH_BS);            // backspace on an empty line is dropped
    send_byte(8'h00);
    send_byte(8'h1f);
    send_byte(CH_NL);
    // Control bytes inside an escape are plain escape data.
    send_byte(CH_ESC);
    send_byte(CH_ESC);
    send_byte(CH_CR);
    send_byte(CH_ESC);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h41);
    send_byte(CH_ESC);
    send_byte(CH_BS);
    send_byte(8'h55);
    send_byte(CH_CR);

    // Overfill the store while the receiver is held off so that the editor
    // backs up and stalls its input.
    hold_off_req = 1'b1;
    for (int k = 0; k < LINE_CAP + 8; k++) send_byte(printable());
    send_byte(CH_CR);

    bytes_taken = 0;
    while (bytes_taken < RANDOM_GOAL) begin
      if (!drained_mid && bytes_taken >= RANDOM_GOAL / 2) begin
        wait_for_drain();
        drained_mid = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_line($urandom_range(0, 10));
        5: send_line($urandom_range(LINE_CAP - 4, LINE_CAP + 12));
        6: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        7: begin
          // Broken escape: the terminator is swallowed as escape data.
          send_byte(CH_ESC);
          send_byte(printable());
          send_byte(CH_CR);
        end
        8: repeat ($urandom_range(1, 5)) send_byte(CH_BS);
        default: begin
          send_byte(CH_ESC);
          send_byte(8'($urandom_range(0, 255)));
          send_byte(8'($urandom_range(0, 255)));
        end
      endcase
    end
    park_sender();

    guard = 0;
    while (tracker.pending() > 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
    if (tracker.pending() > 0)
      report_mismatch($sformatf("%0d expected words never arrived", tracker.pending()));

    $display("Covered %0d words checked over %0d lines, %0d escape pairs, %0d full-store writes.",
             tracker.words_matched, tracker.lines_closed, tracker.escapes_seen,
             tracker.overwrites);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("serial_console_line_editor_unit regression: pass");
    end else begin
      $display("serial_console_line_editor_unit regression: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #8000000;
    $display("serial_console_line_editor_unit regression: fail");
    $finish;
  end

endmodule

FILE: serial_console_line_editor_unit.f
src/sce_pkg.sv
src/sce_in_if.sv
src/sce_out_if.sv
src/serial_console_line_editor_unit.sv
tb/tb_serial_console_line_editor_unit.sv
